>>> rtl/core/swsta_pkg.sv
package swsta_pkg;

    localparam int WIN_DEPTH = 64;
    localparam int ADDR_W    = 6;
    localparam int SMP_W     = 16;
    localparam int DIV_W     = 51;
    localparam int DIVR_W    = 24;
    localparam int STEP_W    = 6;
    localparam int SQRT_W    = 48;
    localparam int ROOT_W    = 24;

    localparam logic [38:0] VAR_MAX = 39'h7F_FFFF_FFFF;
    localparam logic signed [15:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SMP_MIN = -16'sh8000;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> rtl/core/swsta_div.sv
module swsta_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swsta_pkg::t_div_req i_req,
    output swsta_pkg::t_div_rsp o_rsp
);
    import swsta_pkg::*;

    logic [DIV_W-1:0]  r_q;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_div;
    logic [STEP_W-1:0] r_left;
    logic              r_busy;
    logic              r_done;
    logic [DIVR_W:0]   w_trial;
    logic              w_ge;

    // dividend arrives left-aligned; quotient bits shift in at the bottom
    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_left <= i_req.steps;
        end else if (r_busy) begin
            r_left <= r_left - 1'b1;
            if (r_left == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? DIVR_W'(w_trial - {1'b0, r_div}) : w_trial[DIVR_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

>>> rtl/core/swsta_sqrt.sv
module swsta_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swsta_pkg::SQRT_W-2:0]  i_value,
    output logic                          o_done,
    output logic [swsta_pkg::ROOT_W-1:0]  o_root
);
    import swsta_pkg::*;

    logic [SQRT_W-1:0] r_v;
    logic [SQRT_W-1:0] r_r;
    logic [SQRT_W-1:0] r_bit;
    logic              r_busy;
    logic              r_done;
    logic [SQRT_W-1:0] w_try;
    logic              w_ge;

    assign w_try = r_r + r_bit;
    assign w_ge  = r_v >= w_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_bit[1:0] != 2'b00) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // one result bit per cycle, test bit walks down two places each step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= {1'b0, i_value};
            r_r   <= '0;
            r_bit <= SQRT_W'(1) << (SQRT_W - 2);
        end else if (r_busy) begin
            if (w_ge) begin
                r_v <= r_v - w_try;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

>>> rtl/core/sliding_window_statistics.sv
// channel  | direction | tdata / data                         | tuser
// s_axis   | in        | sample                               | req_type
// m_axis   | out       | mean..window_empty, 176 bits         | -
// cfg      | in        | window_length                        | -
//
// One item at a time: a push first evicts the oldest samples while the window
// is full, then stores the sample; a normalize item skips both. Each item then
// scans the ring and runs the mean division, the variance division, the square
// root and the score division in turn; under two samples or a zero deviation
// skips steps. Synchronous active-low reset clears the state; ring contents
// stay unknown. A result waits in the output register; the next item is taken
// once it has been handed on to that register.
module sliding_window_statistics (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // sample
    input  logic          s_axis_tuser,   // req_type
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // mean_q8, variance_q8, stddev_q8, min_value, max_value, normalized_q8,
    // total_count, fill_level, window_ready, window_empty
    output logic [175:0]  m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [6:0]    i_cfg_data      // window_length
);
    import swsta_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVCHK = 4'd1;
    localparam logic [3:0] S_EVSUB = 4'd2;
    localparam logic [3:0] S_SCAN0 = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_MEAN  = 4'd5;
    localparam logic [3:0] S_MEANW = 4'd6;
    localparam logic [3:0] S_VAR0  = 4'd7;
    localparam logic [3:0] S_VAR1  = 4'd8;
    localparam logic [3:0] S_VAR2  = 4'd9;
    localparam logic [3:0] S_VARW  = 4'd10;
    localparam logic [3:0] S_SQRT  = 4'd11;
    localparam logic [3:0] S_SQRTW = 4'd12;
    localparam logic [3:0] S_NORM  = 4'd13;
    localparam logic [3:0] S_NORMW = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [SMP_W-1:0] mem [WIN_DEPTH];
    logic [SMP_W-1:0] r_rd_data;

    logic [3:0]          r_state;
    logic [6:0]          r_wlen;
    logic [ADDR_W-1:0]   r_head;
    logic [6:0]          r_occ;
    logic signed [22:0]  r_sum;
    logic [36:0]         r_sumsq;
    logic [31:0]         r_cnt;
    logic signed [15:0]  r_x;
    logic [6:0]          r_idx;
    logic                r_vld;
    logic signed [15:0]  r_min;
    logic signed [15:0]  r_max;
    logic signed [23:0]  r_mean;
    logic [38:0]         r_var;
    logic [23:0]         r_sd;
    logic signed [15:0]  r_norm;
    logic [42:0]         r_prod;
    logic [42:0]         r_sq;
    logic [11:0]         r_den;
    logic                r_neg;
    logic                r_out_valid;
    logic [175:0]        r_out;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;
    logic                r_div_start;
    logic [DIV_W-1:0]    r_div_dvd;
    logic [DIVR_W-1:0]   r_div_dvs;
    logic [STEP_W-1:0]   r_div_steps;
    logic                r_sqrt_start;
    logic                w_sqrt_done;
    logic [ROOT_W-1:0]   w_root;

    logic [6:0]          w_lim;
    logic                w_evict;
    logic                w_we;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic signed [15:0]  w_old;
    logic signed [31:0]  w_xsq;
    logic signed [31:0]  w_oldsq;
    logic [42:0]         w_prod;
    logic signed [45:0]  w_sumsq_s;
    logic [11:0]         w_den;
    logic signed [44:0]  w_d;
    logic [22:0]         w_sum_abs;
    logic signed [25:0]  w_diff;
    logic [25:0]         w_diff_abs;
    logic [23:0]         w_qlow;

    assign w_lim = (r_wlen == 7'd0) ? 7'd1 :
                   (r_wlen > 7'(WIN_DEPTH)) ? 7'(WIN_DEPTH) : r_wlen;
    assign w_evict = (r_occ != 7'd0) && (r_occ >= w_lim);
    assign w_we    = (r_state == S_EVCHK) && !w_evict;
    assign w_rd_addr = (r_state == S_EVCHK) ? (r_head - r_occ[ADDR_W-1:0]) :
                       (r_head - r_occ[ADDR_W-1:0] + r_idx[ADDR_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_head] <= r_x;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    assign w_old      = r_rd_data;
    assign w_xsq      = r_x * r_x;
    assign w_oldsq    = w_old * w_old;
    assign w_prod     = {36'd0, r_occ} * {6'd0, r_sumsq};
    assign w_sumsq_s  = r_sum * r_sum;
    assign w_den      = 12'(r_occ) * 12'(r_occ - 7'd1);
    assign w_d        = $signed({2'b00, r_prod}) - $signed({2'b00, r_sq});
    assign w_sum_abs  = r_sum[22] ? 23'(-r_sum) : r_sum;
    assign w_diff     = $signed({{2{r_x[15]}}, r_x, 8'd0}) -
                        $signed({{2{r_mean[23]}}, r_mean});
    assign w_diff_abs = w_diff[25] ? 26'(-w_diff) : w_diff;
    assign w_qlow     = w_div_rsp.quotient[23:0];

    assign w_div_req.start    = r_div_start;
    assign w_div_req.dividend = r_div_dvd;
    assign w_div_req.divisor  = r_div_dvs;
    assign w_div_req.steps    = r_div_steps;

    swsta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    swsta_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_start),
        .i_value ({r_var, 8'd0}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wlen       <= 7'd64;
            r_head       <= '0;
            r_occ        <= '0;
            r_sum        <= '0;
            r_sumsq      <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
        end else begin
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            if (i_cfg_valid) begin
                r_wlen <= i_cfg_data;
            end
            // load a new result, or drop the one handed on
            if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= s_axis_tuser ? S_SCAN0 : S_EVCHK;
                    end
                end
                S_EVCHK: begin
                    if (w_evict) begin
                        r_state <= S_EVSUB;
                    end else begin
                        r_head  <= r_head + 1'b1;
                        r_occ   <= r_occ + 1'b1;
                        r_sum   <= r_sum + 23'(r_x);
                        r_sumsq <= r_sumsq + {5'd0, w_xsq};
                        if (r_cnt != 32'hFFFF_FFFF) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= S_SCAN0;
                    end
                end
                S_EVSUB: begin
                    // drop the oldest sample
                    r_sum   <= r_sum - 23'(w_old);
                    r_sumsq <= r_sumsq - {5'd0, w_oldsq};
                    r_occ   <= r_occ - 1'b1;
                    r_state <= S_EVCHK;
                end
                S_SCAN0: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (!(r_idx < r_occ) && !r_vld) begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (r_occ == 7'd0) begin
                        r_state <= S_VAR0;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_MEANW;
                    end
                end
                S_MEANW: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_VAR0;
                    end
                end
                S_VAR0: begin
                    r_state <= (r_occ < 7'd2) ? S_SQRT : S_VAR1;
                end
                S_VAR1: begin
                    r_state <= S_VAR2;
                end
                S_VAR2: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_VARW;
                end
                S_VARW: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sqrt_start <= 1'b1;
                    r_state      <= S_SQRTW;
                end
                S_SQRTW: begin
                    if (w_sqrt_done) begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_sd == 24'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_NORMW;
                    end
                end
                S_NORMW: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x <= s_axis_tdata;
            end
            S_SCAN0: begin
                r_idx <= '0;
                r_vld <= 1'b0;
                r_min <= SMP_MAX;
                r_max <= SMP_MIN;
                r_mean <= '0;
                r_var  <= '0;
                r_norm <= '0;
            end
            S_SCAN: begin
                r_vld <= r_idx < r_occ;
                if (r_idx < r_occ) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_vld) begin
                    if (w_old < r_min) r_min <= w_old;
                    if (w_old > r_max) r_max <= w_old;
                end
            end
            S_MEAN: begin
                r_neg       <= r_sum[22];
                r_div_dvd   <= {w_sum_abs[21:0], 8'd0, 21'd0};
                r_div_dvs   <= {17'd0, r_occ};
                r_div_steps <= STEP_W'(30);
            end
            S_MEANW: begin
                r_mean <= r_neg ? -$signed(w_qlow) : $signed(w_qlow);
            end
            S_VAR0: begin
                r_prod <= w_prod;
                r_den  <= w_den;
            end
            S_VAR1: begin
                r_sq <= w_sumsq_s[42:0];
            end
            S_VAR2: begin
                r_div_dvd   <= w_d[44] ? '0 : {w_d[42:0], 8'd0};
                r_div_dvs   <= {12'd0, r_den};
                r_div_steps <= STEP_W'(DIV_W);
            end
            S_VARW: begin
                r_var <= (w_div_rsp.quotient > {12'd0, VAR_MAX}) ? VAR_MAX :
                         w_div_rsp.quotient[38:0];
            end
            S_SQRTW: begin
                r_sd <= w_root;
            end
            S_NORM: begin
                r_neg       <= w_diff[25];
                r_div_dvd   <= {w_diff_abs[24:0], 8'd0, 18'd0};
                r_div_dvs   <= r_sd;
                r_div_steps <= STEP_W'(33);
            end
            S_NORMW: begin
                if (r_neg) begin
                    r_norm <= (w_div_rsp.quotient[32:0] > 33'd32768) ? SMP_MIN :
                              -$signed(w_div_rsp.quotient[15:0]);
                end else begin
                    r_norm <= (w_div_rsp.quotient[32:0] > 33'd32767) ? SMP_MAX :
                              $signed(w_div_rsp.quotient[15:0]);
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out <= {(r_occ == 7'd0), (r_cnt >= {25'd0, w_lim}),
                              r_occ, r_cnt, r_norm, r_max, r_min, r_sd, r_var, r_mean};
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign o_cfg_ready   = 1'b1;

endmodule

>>> rtl/core/swsta_chk.sv
module swsta_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [175:0]  m_axis_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one item at a time
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while another is in progress");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[175] == (m_axis_tdata[173:167] == 7'd0)))
        else $error("empty flag disagrees with fill");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[173:167] <= 7'd64))
        else $error("fill above window depth");

    a_var_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[173:167] < 7'd2) |->
            (m_axis_tdata[62:24] == 39'd0) && (m_axis_tdata[134:119] == 16'd0))
        else $error("variance or score nonzero with fewer than two samples");

endmodule

bind sliding_window_statistics swsta_chk u_swsta_chk (.*);
